/* src/block_cache_tag_controller_unit_defines.svh */
// Assertion macros shared by the checker of the block cache tag controller.
// Depends on nothing; included by the checker file only.
`ifndef BLOCK_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`define BLOCK_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BCTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BCTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bctc_pkg.sv */
// Shared constants, types and helpers for the block cache tag controller.
// Depends on nothing; used by the controller, the datapath and the top level.
package bctc_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned DEV_W  = 8;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned SLOT_FIELD_W = 4;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic victim_rd;
    logic finish_hit;
    logic finish_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;
    logic match;
    logic last_cmp;
  } sts_t;

  // The slot field carries the low bits of the slot index.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
    ext = {{SLOT_FIELD_W{1'b0}}, idx};
    return ext[SLOT_FIELD_W-1:0];
  endfunction

endpackage

/* src/bctc_ctrl.sv */
// Sequencer of the block cache tag controller: scan, victim read and commit.
// Depends on bctc_pkg; drives the datapath bctc_dpath through cmd_t.
module bctc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bctc_pkg::sts_t sts_i,
  output bctc_pkg::cmd_t cmd_o
);

  bctc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bctc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      bctc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = bctc_pkg::ST_SCAN;
        end
      end
      bctc_pkg::ST_SCAN: begin
        if (sts_i.match) begin
          cmd_o.finish_hit = 1'b1;
          state_d          = bctc_pkg::ST_IDLE;
        end else if (sts_i.last_cmp) begin
          cmd_o.victim_rd = 1'b1;
          state_d         = bctc_pkg::ST_VICTIM;
        end else begin
          cmd_o.scan_rd = !sts_i.issue_done;
        end
      end
      bctc_pkg::ST_VICTIM: begin
        cmd_o.finish_miss = 1'b1;
        state_d           = bctc_pkg::ST_IDLE;
      end
      default: begin
        state_d = bctc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/bctc_dpath.sv */
// Datapath of the block cache tag controller: tag memory, slot state bits,
// victim pointer, tag compare and result registers. Depends on bctc_pkg.
module bctc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bctc_pkg::cmd_t                      cmd_i,
  output bctc_pkg::sts_t                      sts_o,
  input  logic                                action_i,
  input  logic [bctc_pkg::DEV_W-1:0]          device_i,
  input  logic [bctc_pkg::BLK_W-1:0]          block_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [bctc_pkg::SLOT_FIELD_W-1:0]   slot_o,
  output logic                                fill_needed_o,
  output logic                                writeback_needed_o,
  output logic [bctc_pkg::DEV_W-1:0]          victim_device_o,
  output logic [bctc_pkg::BLK_W-1:0]          victim_block_o
);

  // Tag store; entries are only trusted while their valid bit is set.
  bctc_pkg::tag_t tag_mem [bctc_pkg::SLOTS];

  logic                          req_write_q;
  bctc_pkg::tag_t                req_tag_q;
  logic [bctc_pkg::CNT_W-1:0]    scan_q;
  logic                          rd_vld_q;
  logic [bctc_pkg::SLOT_W-1:0]   rd_idx_q;
  bctc_pkg::tag_t                rdata_q;
  logic [bctc_pkg::SLOT_W-1:0]   vp_q, vp_nxt;
  logic [bctc_pkg::SLOTS-1:0]    valid_q, valid_d;
  logic [bctc_pkg::SLOTS-1:0]    dirty_q, dirty_d;
  logic [bctc_pkg::SLOT_W-1:0]   rd_addr;
  logic                          rd_en;
  logic                          victim_wb;

  logic                                done_q;
  logic                                hit_q;
  logic [bctc_pkg::SLOT_FIELD_W-1:0]   slot_q;
  logic                                fill_q;
  logic                                wb_q;
  logic [bctc_pkg::DEV_W-1:0]          vdev_q;
  logic [bctc_pkg::BLK_W-1:0]          vblk_q;

  assign vp_nxt  = (vp_q == bctc_pkg::SLOT_W'(bctc_pkg::SLOTS - 1)) ? '0 : vp_q + 1'b1;
  assign rd_addr = cmd_i.victim_rd ? vp_nxt : scan_q[bctc_pkg::SLOT_W-1:0];
  assign rd_en   = cmd_i.scan_rd | cmd_i.victim_rd;

  assign sts_o.issue_done = (scan_q == bctc_pkg::CNT_W'(bctc_pkg::SLOTS));
  assign sts_o.match      = rd_vld_q && valid_q[rd_idx_q] && (rdata_q == req_tag_q);
  assign sts_o.last_cmp   = rd_vld_q &&
                            (rd_idx_q == bctc_pkg::SLOT_W'(bctc_pkg::SLOTS - 1));

  assign victim_wb = valid_q[vp_q] && dirty_q[vp_q];

  // Tag memory: one read and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= tag_mem[rd_addr];
    end
    if (cmd_i.finish_miss) begin
      tag_mem[vp_q] <= req_tag_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (cmd_i.finish_hit && req_write_q) begin
      dirty_d[rd_idx_q] = 1'b1;
    end
    if (cmd_i.finish_miss) begin
      valid_d[vp_q] = 1'b1;
      dirty_d[vp_q] = req_write_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      dirty_q  <= '0;
      vp_q     <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      dirty_q  <= dirty_d;
      rd_vld_q <= cmd_i.scan_rd;
      done_q   <= cmd_i.finish_hit | cmd_i.finish_miss;
      if (cmd_i.victim_rd) begin
        vp_q <= vp_nxt;
      end
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_write_q   <= action_i;
      req_tag_q.dev <= device_i;
      req_tag_q.blk <= block_i;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= scan_q[bctc_pkg::SLOT_W-1:0];
    end
    if (cmd_i.finish_hit) begin
      hit_q  <= 1'b1;
      slot_q <= bctc_pkg::slot_field(rd_idx_q);
      fill_q <= 1'b0;
      wb_q   <= 1'b0;
      vdev_q <= '0;
      vblk_q <= '0;
    end else if (cmd_i.finish_miss) begin
      hit_q  <= 1'b0;
      slot_q <= bctc_pkg::slot_field(vp_q);
      fill_q <= !req_write_q;
      wb_q   <= victim_wb;
      vdev_q <= victim_wb ? rdata_q.dev : '0;
      vblk_q <= victim_wb ? rdata_q.blk : '0;
    end
  end

  assign done_o             = done_q;
  assign hit_o              = hit_q;
  assign slot_o             = slot_q;
  assign fill_needed_o      = fill_q;
  assign writeback_needed_o = wb_q;
  assign victim_device_o    = vdev_q;
  assign victim_block_o     = vblk_q;

endmodule

/* src/block_cache_tag_controller_unit.sv */
// Top level of the block cache tag controller: joins controller and datapath.
// Depends on bctc_pkg, bctc_ctrl and bctc_dpath.
//
// A request (action, device, block) is taken at a rising edge where start is
// high and busy is low. The block then compares the request with one stored
// tag per cycle, slot 0 upwards, through the single read port of the tag
// memory, and stops at the first valid slot that matches. A hit in slot k
// ends the scan once slot k has been compared; a miss also needs a read of
// the victim slot's old tag after the full scan of all SLOTS slots, which
// comes before its result is registered. The result appears for exactly one
// cycle with done_o high, in the same cycle that busy falls, and there is no
// way to hold it: the receiver must take every beat as it comes. A new request
// may be presented in that same cycle. On a miss the round-robin victim
// pointer advances first, so after reset the first miss lands in slot 1; if
// that slot held a dirty block its old device and block number come out with
// writeback_needed_o, and a read miss asks for a fill. Hits never change the
// replacement order. No clearing pass is needed after reset: the valid and
// dirty bits clear at once and the tag memory is ignored until written.
module block_cache_tag_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [bctc_pkg::DEV_W-1:0]          device_i,
  input  logic [bctc_pkg::BLK_W-1:0]          block_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [bctc_pkg::SLOT_FIELD_W-1:0]   slot_o,
  output logic                                fill_needed_o,
  output logic                                writeback_needed_o,
  output logic [bctc_pkg::DEV_W-1:0]          victim_device_o,
  output logic [bctc_pkg::BLK_W-1:0]          victim_block_o
);

  bctc_pkg::cmd_t cmd;
  bctc_pkg::sts_t sts;

  // The controller sequences each access; it sees only start and the status bits.
  bctc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // The datapath holds every tag, slot state bit and result register.
  bctc_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .device_i           (device_i),
    .block_i            (block_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .slot_o             (slot_o),
    .fill_needed_o      (fill_needed_o),
    .writeback_needed_o (writeback_needed_o),
    .victim_device_o    (victim_device_o),
    .victim_block_o     (victim_block_o)
  );

endmodule

/* src/bctc_checker.sv */
// Port-level checker for the block cache tag controller, bound to the top level.
// Depends on bctc_pkg and the assertion macros in the defines header.
`include "block_cache_tag_controller_unit_defines.svh"

module bctc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic                                hit_o,
  input logic                                fill_needed_o,
  input logic                                writeback_needed_o,
  input logic [bctc_pkg::DEV_W-1:0]          victim_device_o,
  input logic [bctc_pkg::BLK_W-1:0]          victim_block_o
);

  `BCTC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "busy not raised after accept")
  `BCTC_ASSERT_NOW(a_fall_done, clk_i, rst_ni, $fell(busy), done_o, "busy fell without a result beat")
  `BCTC_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy && !$past(done_o), "result beat not single")
  `BCTC_ASSERT_NOW(a_hit_quiet, clk_i, rst_ni, done_o && hit_o, !fill_needed_o && !writeback_needed_o, "hit requested fill or writeback")
  `BCTC_ASSERT_NOW(a_victim_zero, clk_i, rst_ni, done_o && !writeback_needed_o, victim_device_o == '0 && victim_block_o == '0, "victim fields set without writeback")

endmodule

bind block_cache_tag_controller_unit bctc_checker u_bctc_checker (.*);

/* tb/block_cache_tag_controller_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the block cache tag controller: hits, misses, round-robin
// eviction and dirty writeback. Depends on bctc_pkg and block_cache_tag_controller_unit.
module block_cache_tag_controller_unit_tb;

  localparam int unsigned SLOTS        = bctc_pkg::SLOTS;
  localparam int unsigned DEV_W        = bctc_pkg::DEV_W;
  localparam int unsigned BLK_W        = bctc_pkg::BLK_W;
  localparam int unsigned SLOT_FIELD_W = bctc_pkg::SLOT_FIELD_W;

  localparam int unsigned RANDOM_ACCESSES = 1450;
  // The final stretch of the run is sent back to back, with no idling.
  localparam int unsigned CALM_TAIL       = 250;
  // A working set somewhat larger than the cache gives a healthy mix of hits,
  // misses and evictions of blocks that are still being used.
  localparam int unsigned WORKING_SET     = 24;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } access_e;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    fill;
    logic                    writeback;
    logic [DEV_W-1:0]        victim_dev;
    logic [BLK_W-1:0]        victim_blk;
  } outcome_t;

  // Tag directory of its own, with the queue of outcomes still to be seen
  // on the result port.
  class cache_tag_scoreboard;
    logic [DEV_W-1:0] tag_dev [SLOTS];
    logic [BLK_W-1:0] tag_blk [SLOTS];
    bit               valid   [SLOTS];
    bit               dirty   [SLOTS];
    int unsigned      victim_ptr;
    outcome_t         expected_outcomes [$];
    int unsigned      failures;

    function new();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        dirty[i] = 1'b0;
      end
      victim_ptr = 0;
      failures   = 0;
    endfunction

    function void note_access(access_e act, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
      outcome_t    res;
      int unsigned idx;
      bit          found;
      res   = '0;
      idx   = 0;
      found = 1'b0;
      // The lowest matching valid slot wins.
      for (int unsigned i = 0; i < SLOTS && !found; i++) begin
        if (valid[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
          idx   = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.hit = 1'b1;
      end else begin
        // The pointer moves before it is used, so the first miss lands in slot 1.
        victim_ptr = (victim_ptr + 1) % SLOTS;
        idx        = victim_ptr;
        if (valid[idx] && dirty[idx]) begin
          res.writeback  = 1'b1;
          res.victim_dev = tag_dev[idx];
          res.victim_blk = tag_blk[idx];
        end
        tag_dev[idx] = dev;
        tag_blk[idx] = blk;
        valid[idx]   = 1'b1;
        dirty[idx]   = 1'b0;
        res.fill     = (act == ACT_READ);
      end
      if (act == ACT_WRITE) begin
        dirty[idx] = 1'b1;
      end
      res.slot = idx[SLOT_FIELD_W-1:0];
      expected_outcomes.push_back(res);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: result beat with nothing outstanding: hit %0b slot %0d fill %0b wb %0b",
                   $time, got.hit, got.slot, got.fill, got.writeback);
        end
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot || got.fill !== want.fill ||
          got.writeback !== want.writeback || got.victim_dev !== want.victim_dev ||
          got.victim_blk !== want.victim_blk) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: expected hit %0b slot %0d fill %0b wb %0b victim %h/%h", $time,
                   want.hit, want.slot, want.fill, want.writeback, want.victim_dev,
                   want.victim_blk);
          $display("%0t:      got hit %0b slot %0d fill %0b wb %0b victim %h/%h", $time,
                   got.hit, got.slot, got.fill, got.writeback, got.victim_dev, got.victim_blk);
        end
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    action_i;
  logic [DEV_W-1:0]        device_i;
  logic [BLK_W-1:0]        block_i;
  logic                    done_o;
  logic                    hit_o;
  logic [SLOT_FIELD_W-1:0] slot_o;
  logic                    fill_needed_o;
  logic                    writeback_needed_o;
  logic [DEV_W-1:0]        victim_device_o;
  logic [BLK_W-1:0]        victim_block_o;

  cache_tag_scoreboard sb;

  block_cache_tag_controller_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .device_i           (device_i),
    .block_i            (block_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .slot_o             (slot_o),
    .fill_needed_o      (fill_needed_o),
    .writeback_needed_o (writeback_needed_o),
    .victim_device_o    (victim_device_o),
    .victim_block_o     (victim_block_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Presents one access and holds it until the block takes the beat. It is
  // called at a rising edge and returns at the edge where the beat was taken,
  // with start still high so that a following access can go straight out.
  task automatic send_access(access_e act, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
    action_i <= act;
    device_i <= dev;
    block_i  <= blk;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds the request line low for a burst of idle cycles.
  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops sending and waits until every outstanding outcome has come back.
  // The first edge lets the monitor record the beat that was just taken, so
  // the queue cannot look empty too early.
  task automatic drain_outcomes();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.expected_outcomes.size() != 0);
  endtask

  // Monitor and watchdog. Both sides are sampled at the rising edge, before
  // the block's registers move, so the values seen are those of the cycle
  // that the edge closes. A result beat is checked before any access taken
  // at the same edge is noted, since a result never belongs to a request
  // taken at that same edge.
  always @(posedge clk_i) begin : monitor
    int unsigned quiet_cycles;
    if (rst_ni) begin
      if (done_o) begin
        sb.check_outcome({hit_o, slot_o, fill_needed_o, writeback_needed_o,
                          victim_device_o, victim_block_o});
      end
      if (start && !busy) begin
        sb.note_access(access_e'(action_i), device_i, block_i);
      end
      // Nothing moving on either side for this long means the block has hung.
      if (done_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("block_cache_tag_controller_unit_tb failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin : stimulus
    logic [DEV_W-1:0] set_dev [WORKING_SET];
    logic [BLK_W-1:0] set_blk [WORKING_SET];
    int unsigned      pick;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;

    sb       = new();
    rst_ni   <= 1'b0;
    start    <= 1'b0;
    action_i <= ACT_READ;
    device_i <= '0;
    block_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A read miss into an empty cache lands in slot 1 and
    // asks for a fill; reading it again hits; writing it hits and dirties it.
    send_access(ACT_READ, 8'h00, 32'h0000_0000);
    send_access(ACT_READ, 8'h00, 32'h0000_0000);
    send_access(ACT_WRITE, 8'h00, 32'h0000_0000);
    // A write miss at the top of both ranges: no fill, slot marked dirty.
    send_access(ACT_WRITE, 8'hFF, 32'hFFFF_FFFF);
    // Tags that differ from a cached one in the block alone or the device
    // alone must both miss.
    send_access(ACT_READ, 8'hFF, 32'hFFFF_FFFE);
    send_access(ACT_READ, 8'hFE, 32'hFFFF_FFFF);
    send_access(ACT_WRITE, 8'hFF, 32'hFFFF_FFFF);
    // Fill the rest of the cache so that the pointer wraps through slot 0;
    // the last two misses evict the two dirty blocks from above and so must
    // report them for writeback.
    for (int unsigned k = 0; k < 14; k++) begin
      send_access(access_e'(k[0] ? ACT_WRITE : ACT_READ), k[0] ? 8'hAA : 8'h55,
                  k[0] ? 32'h5555_5500 + k : 32'hAAAA_AA00 + k);
    end
    // A hit in slot 0, which holds the block placed by the wrap.
    send_access(ACT_WRITE, 8'hAA, 32'h5555_5500 + 11);
    drain_outcomes();

    // Random part: accesses drawn mostly from a working set, whose entries
    // are now and then replaced by fresh tags or by near neighbours of the
    // old ones, so that comparisons that differ in a single bit are common.
    foreach (set_dev[i]) begin
      set_dev[i] = DEV_W'($urandom);
      set_blk[i] = $urandom;
    end
    for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
      // Once, half way through, the sender waits for the block to go quiet.
      if (n == RANDOM_ACCESSES / 2) begin
        drain_outcomes();
      end
      // Idling comes in windows, with stretches of back-to-back beats between.
      if (n < RANDOM_ACCESSES - CALM_TAIL && (n / 100) % 3 != 2 &&
          $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 6));
      end
      pick = $urandom_range(0, WORKING_SET - 1);
      case ($urandom_range(0, 7))
        0: begin
          set_dev[pick] = DEV_W'($urandom);
          set_blk[pick] = $urandom;
        end
        1: begin
          set_blk[pick] = set_blk[pick] ^ (32'h1 << $urandom_range(0, BLK_W - 1));
        end
        2: begin
          set_dev[pick] = set_dev[pick] ^ (8'h1 << $urandom_range(0, DEV_W - 1));
        end
        default: begin
        end
      endcase
      dev = set_dev[pick];
      blk = set_blk[pick];
      send_access(access_e'($urandom_range(0, 1)), dev, blk);
    end

    drain_outcomes();
    // Any stray beat after the last expected one would show within a scan.
    repeat (SLOTS + 8) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_outcomes.size() == 0) begin
      $display("block_cache_tag_controller_unit_tb passed");
    end else begin
      $display("block_cache_tag_controller_unit_tb failed");
    end
    $finish;
  end

endmodule
